>>> rtl/wcep_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the wireframe cube edge projector.
// No dependencies; wcep_front, wcep_back and the top level import this package.
package wcep_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int COORD_FRAC_BITS   = 14;
    localparam int SCREEN_COORD_BITS = 12;

    localparam int WFRAC        = COORD_FRAC_BITS + 1;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    localparam int TRIG_W  = COORD_FRAC_BITS + 2;
    localparam int XY_W    = TRIG_W + 1;
    localparam int P_W     = TRIG_W + XY_W;
    localparam int DIST_W  = (WFRAC >= 12) ? 16 + WFRAC - 12 : 16;
    localparam int DEN_W   = DIST_W + 1;
    localparam int K_W     = DIST_W + 8;
    localparam int PROD_W  = XY_W + K_W + 1;
    localparam int NUM_W   = PROD_W - WFRAC;
    localparam int COORD_W = NUM_W + 2;
    localparam int DEP_W   = 48;
    localparam int FLOOR_D = ((1 << WFRAC) + 5) / 10;

    localparam int VERTS      = 8;
    localparam int VERT_IDX_W = 3;
    localparam int EDGES      = 12;
    localparam int EDGE_IDX_W = 4;
    localparam int VTX_W      = 2 * SCREEN_COORD_BITS + XY_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_DIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THRESH = 3'd4;

    localparam logic [1:0] DEPTH_FRONT = 2'd0;
    localparam logic [1:0] DEPTH_SIDE  = 2'd1;
    localparam logic [1:0] DEPTH_BACK  = 2'd2;

    typedef struct packed {
        logic [15:0] yaw_angle;
        logic [15:0] pitch_angle;
    } t_in;

    typedef struct packed {
        logic signed [SCREEN_COORD_BITS-1:0] start_x;
        logic signed [SCREEN_COORD_BITS-1:0] start_y;
        logic signed [SCREEN_COORD_BITS-1:0] end_x;
        logic signed [SCREEN_COORD_BITS-1:0] end_y;
        logic [1:0]                          depth_class;
        logic                                last_edge;
    } t_out;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cy;
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sp;
    } t_trig;

    typedef struct packed {
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [7:0]  pixel_scale;
        logic [15:0] camera_distance;
        logic [13:0] depth_threshold;
    } t_cfg;

    // Arctangent of 2^-i in units of 2^-32 turns.
    function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Sign bits of a vertex: bit0 x, bit1 y, bit2 z (set means +0.5).
    function automatic logic [2:0] vert_sign(input logic [VERT_IDX_W-1:0] v);
        logic [2:0] r;
        unique case (v)
            3'd0: r = 3'b000;
            3'd1: r = 3'b001;
            3'd2: r = 3'b011;
            3'd3: r = 3'b010;
            3'd4: r = 3'b100;
            3'd5: r = 3'b101;
            3'd6: r = 3'b111;
            3'd7: r = 3'b110;
        endcase
        return r;
    endfunction

    function automatic logic [VERT_IDX_W-1:0] edge_a(input logic [EDGE_IDX_W-1:0] e);
        logic [VERT_IDX_W-1:0] r;
        case (e)
            4'd0, 4'd3, 4'd8:  r = 3'd0;
            4'd1, 4'd9:        r = 3'd1;
            4'd2, 4'd10:       r = 3'd2;
            4'd11:             r = 3'd3;
            4'd4:              r = 3'd4;
            4'd5:              r = 3'd5;
            4'd6:              r = 3'd6;
            4'd7:              r = 3'd7;
            default:           r = 3'd0;
        endcase
        if (e == 4'd3) begin
            r = 3'd3;
        end
        return r;
    endfunction

    function automatic logic [VERT_IDX_W-1:0] edge_b(input logic [EDGE_IDX_W-1:0] e);
        logic [VERT_IDX_W-1:0] r;
        case (e)
            4'd0:  r = 3'd1;
            4'd1:  r = 3'd2;
            4'd2:  r = 3'd3;
            4'd3:  r = 3'd0;
            4'd4:  r = 3'd5;
            4'd5:  r = 3'd6;
            4'd6:  r = 3'd7;
            4'd7:  r = 3'd4;
            4'd8:  r = 3'd4;
            4'd9:  r = 3'd5;
            4'd10: r = 3'd6;
            4'd11: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [SCREEN_COORD_BITS-1:0] sat_screen(
        input logic signed [COORD_W-1:0] v
    );
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] lo;
        hi = COORD_W'((64'sd1 <<< (SCREEN_COORD_BITS - 1)) - 64'sd1);
        lo = -hi - COORD_W'(1);
        if (v > hi) begin
            return hi[SCREEN_COORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[SCREEN_COORD_BITS-1:0];
        end
        return v[SCREEN_COORD_BITS-1:0];
    endfunction

endpackage

>>> rtl/wcep_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wcep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/wcep_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module wcep_div #(
    parameter int N_W = 30,
    parameter int D_W = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_n;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_d;
    logic [D_W:0]     sh;
    logic             fits;

    assign sh   = {r_rem, r_n[N_W-1]};
    assign fits = sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // For a nonzero divisor the partial remainder stays below the divisor.
            r_rem <= fits ? D_W'(sh - {1'b0, r_d}) : sh[D_W-1:0];
            r_n   <= {r_n[N_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n;
endmodule

>>> rtl/wcep_front.sv
`timescale 1ns / 1ps
// Front end: accepts a frame, runs the iterative CORDIC for yaw and pitch
// and queues the sine/cosine sets for the back end. Depends on wcep_pkg.
module wcep_front import wcep_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_in   i_item,
    output logic  o_busy,
    output logic  o_q_valid,
    output t_trig o_q_trig,
    input  logic  i_q_pop
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_YAW   = 2'd1;
    localparam logic [1:0] ST_PITCH = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;
    localparam int SHR = 30 - COORD_FRAC_BITS;

    logic [1:0]           r_state;
    logic [STEP_W-1:0]    r_step;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_flip;
    logic [15:0]          r_pitch;
    logic signed [TRIG_W-1:0] r_cy, r_sy, r_cp, r_sp;

    t_trig r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic  push;

    logic [15:0]          sel_ang;
    logic [31:0]          a_full, a_off, a_adj;
    logic                 init_flip;
    logic signed [CW-1:0] init_z;
    logic signed [CW-1:0] dx, dy, fx, fy, rx, ry;
    logic                 step_done;

    assign sel_ang   = (r_state == ST_IDLE) ? i_item.yaw_angle : r_pitch;
    assign a_full    = (32'(sel_ang) & ANG_MASK) << (32 - ANGLE_BITS);
    assign a_off     = a_full - 32'h4000_0000;
    assign init_flip = ~a_off[31];
    assign a_adj     = init_flip ? (a_full ^ 32'h8000_0000) : a_full;
    assign init_z    = CW'(signed'(a_adj));

    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign step_done = (r_step == STEP_W'(CORDIC_STEPS));

    // Undo the half-turn fold, then round half up to the coordinate format.
    assign fx = r_flip ? -r_x : r_x;
    assign fy = r_flip ? -r_y : r_y;
    assign rx = (fx + (CW'(1) <<< (SHR - 1))) >>> SHR;
    assign ry = (fy + (CW'(1) <<< (SHR - 1))) >>> SHR;

    assign push = (r_state == ST_PUSH) && (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_YAW;
                        r_step  <= '0;
                    end
                end
                ST_YAW: begin
                    if (step_done) begin
                        r_state <= ST_PITCH;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                ST_PITCH: begin
                    if (step_done) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                ST_PUSH: begin
                    if (push) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE && i_start) || (r_state == ST_YAW && step_done)) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= init_z;
            r_flip <= init_flip;
        end else if (!step_done) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_turn(r_step);
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_turn(r_step);
            end
        end
        if (r_state == ST_IDLE && i_start) begin
            r_pitch <= i_item.pitch_angle;
        end
        if (r_state == ST_YAW && step_done) begin
            r_cy <= rx[TRIG_W-1:0];
            r_sy <= ry[TRIG_W-1:0];
        end
        if (r_state == ST_PITCH && step_done) begin
            r_cp <= rx[TRIG_W-1:0];
            r_sp <= ry[TRIG_W-1:0];
        end
        if (push) begin
            r_q[r_wp] <= '{cy: r_cy, sy: r_sy, cp: r_cp, sp: r_sp};
        end
    end

    // Two-entry queue towards the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_trig  = r_q[r_rp];
endmodule

>>> rtl/wcep_back.sv
`timescale 1ns / 1ps
// Back end: rotates and projects the eight vertices, then emits the cube's
// edges. Depends on wcep_pkg, wcep_div and wcep_ram.
module wcep_back import wcep_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_trig i_q_trig,
    output logic  o_q_pop,
    output logic  o_valid,
    output t_out  o_result
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_KMUL = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_MX   = 4'd5;
    localparam logic [3:0] ST_MY   = 4'd6;
    localparam logic [3:0] ST_DST  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_WR   = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;
    localparam int S = SCREEN_COORD_BITS;
    localparam int F = COORD_FRAC_BITS;

    logic [3:0]              r_state;
    t_trig                   r_trig;
    logic [VERT_IDX_W-1:0]   r_v;
    logic [EDGE_IDX_W-1:0]   r_e;
    logic [K_W-1:0]          r_k;
    logic signed [P_W-1:0]   r_p;
    logic signed [XY_W-1:0]  r_y2, r_z2;
    logic [DEN_W-1:0]        r_den;
    logic signed [PROD_W-1:0] r_nx, r_ny;
    logic                    r_rv;
    logic [EDGE_IDX_W-1:0]   r_re;
    logic                    r_out_valid;
    t_out                    r_out;

    logic [DIST_W-1:0]        cam_dist;
    logic [2:0]               sg;
    logic signed [XY_W-1:0]   x1, z1, cy_e, sy_e, cp_y, sp_y;
    logic signed [K_W:0]      k_s;
    logic signed [P_W-1:0]    p_y2, p_z2;
    logic signed [DIST_W+1:0] den_s;
    logic [PROD_W-1:0]        mag_x, mag_y;
    logic                     div_start, dx_done, dy_done;
    logic [NUM_W-1:0]         qx, qy;
    logic signed [COORD_W-1:0] cx_full, cy_full;
    logic signed [S-1:0]      px, py;
    logic [VTX_W-1:0]         wdata, rd_a, rd_b;
    logic signed [XY_W:0]     zsum;
    logic signed [DEP_W-1:0]  lhs, bound;
    logic [1:0]               cls;

    generate
        if (WFRAC >= 12) begin : g_dist_up
            assign cam_dist = DIST_W'(i_cfg.camera_distance) << (WFRAC - 12);
        end else begin : g_dist_dn
            assign cam_dist = DIST_W'(i_cfg.camera_distance >> (12 - WFRAC));
        end
    endgenerate

    assign sg   = vert_sign(r_v);
    assign cy_e = XY_W'(r_trig.cy);
    assign sy_e = XY_W'(r_trig.sy);
    assign x1   = (sg[0] ? cy_e : -cy_e) + (sg[2] ? sy_e : -sy_e);
    assign z1   = (sg[0] ? -sy_e : sy_e) + (sg[2] ? cy_e : -cy_e);
    assign cp_y = sg[1] ? XY_W'(r_trig.cp) : -XY_W'(r_trig.cp);
    assign sp_y = sg[1] ? XY_W'(r_trig.sp) : -XY_W'(r_trig.sp);
    assign k_s  = signed'({1'b0, r_k});

    // The y1 term is a power of two, so only the z1 products need a multiplier.
    assign p_y2 = (-r_p + (P_W'(1) <<< (F - 1))) >>> F;
    assign p_z2 = (r_p + (P_W'(1) <<< (F - 1))) >>> F;

    assign den_s = signed'({2'b00, cam_dist}) - (DIST_W + 2)'(r_z2);

    assign mag_x = r_nx[PROD_W-1] ? PROD_W'(-r_nx) : PROD_W'(r_nx);
    assign mag_y = r_ny[PROD_W-1] ? PROD_W'(-r_ny) : PROD_W'(r_ny);
    assign div_start = (r_state == ST_DST);

    wcep_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag_x[PROD_W-1:WFRAC]),
        .i_den   (r_den),
        .o_done  (dx_done),
        .o_quot  (qx)
    );

    wcep_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag_y[PROD_W-1:WFRAC]),
        .i_den   (r_den),
        .o_done  (dy_done),
        .o_quot  (qy)
    );

    assign cx_full = (r_nx[PROD_W-1] ? -signed'({2'b00, qx}) : signed'({2'b00, qx}))
                   + signed'(COORD_W'(i_cfg.center_x));
    assign cy_full = (r_ny[PROD_W-1] ? -signed'({2'b00, qy}) : signed'({2'b00, qy}))
                   + signed'(COORD_W'(i_cfg.center_y));
    assign px    = sat_screen(cx_full);
    assign py    = sat_screen(cy_full);
    assign wdata = {px, py, r_z2};

    wcep_ram #(.WIDTH(VTX_W), .DEPTH(VERTS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WR),
        .i_waddr (r_v),
        .i_wdata (wdata),
        .i_raddr (edge_a(r_e)),
        .o_rdata (rd_a)
    );

    wcep_ram #(.WIDTH(VTX_W), .DEPTH(VERTS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WR),
        .i_waddr (r_v),
        .i_wdata (wdata),
        .i_raddr (edge_b(r_e)),
        .o_rdata (rd_b)
    );

    // Exact comparison of the summed endpoint depths against twice the threshold.
    assign zsum  = (XY_W + 1)'(signed'(rd_a[XY_W-1:0])) + (XY_W + 1)'(signed'(rd_b[XY_W-1:0]));
    assign lhs   = DEP_W'(zsum) <<< 14;
    assign bound = signed'(DEP_W'(i_cfg.depth_threshold) << (WFRAC + 1));
    assign cls   = (lhs > bound) ? DEPTH_FRONT : ((lhs < -bound) ? DEPTH_BACK : DEPTH_SIDE);

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v         <= '0;
            r_e         <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv        <= (r_state == ST_EMIT);
            r_out_valid <= r_rv;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_KMUL;
                        r_v     <= '0;
                    end
                end
                ST_KMUL: r_state <= ST_M1;
                ST_M1:   r_state <= ST_M2;
                ST_M2:   r_state <= ST_M3;
                ST_M3:   r_state <= ST_MX;
                ST_MX:   r_state <= ST_MY;
                ST_MY:   r_state <= ST_DST;
                ST_DST:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (dx_done && dy_done) begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    r_v <= r_v + VERT_IDX_W'(1);
                    if (r_v == VERT_IDX_W'(VERTS - 1)) begin
                        r_state <= ST_EMIT;
                        r_e     <= '0;
                    end else begin
                        r_state <= ST_M1;
                    end
                end
                ST_EMIT: begin
                    r_e <= r_e + EDGE_IDX_W'(1);
                    if (r_e == EDGE_IDX_W'(EDGES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_trig <= i_q_trig;
        end
        if (r_state == ST_KMUL) begin
            r_k <= K_W'(cam_dist * i_cfg.pixel_scale);
        end
        if (r_state == ST_M1) begin
            r_p <= r_trig.sp * z1;
        end
        if (r_state == ST_M2) begin
            r_y2 <= cp_y + XY_W'(p_y2);
            r_p  <= r_trig.cp * z1;
        end
        if (r_state == ST_M3) begin
            r_z2 <= sp_y + XY_W'(p_z2);
        end
        if (r_state == ST_MX) begin
            r_den <= (den_s < (DIST_W + 2)'(FLOOR_D)) ? DEN_W'(FLOOR_D) : DEN_W'(den_s);
            r_nx  <= x1 * k_s;
        end
        if (r_state == ST_MY) begin
            r_ny <= -(r_y2 * k_s);
        end
        r_re <= r_e;
        if (r_rv) begin
            r_out.start_x     <= rd_a[VTX_W-1 -: S];
            r_out.start_y     <= rd_a[XY_W +: S];
            r_out.end_x       <= rd_b[VTX_W-1 -: S];
            r_out.end_y       <= rd_b[XY_W +: S];
            r_out.depth_class <= cls;
            r_out.last_edge   <= (r_re == EDGE_IDX_W'(EDGES - 1));
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
endmodule

>>> rtl/wireframe_cube_edge_projector.sv
`timescale 1ns / 1ps
// Top level of the wireframe cube edge projector: configuration registers,
// front end and back end. Depends on wcep_pkg, wcep_front and wcep_back.
//
//  Channel   Signals                              Transfer when
//  -------   -----------------------------------  ---------------------------
//  frame     start, busy, i_item                  start high and busy low
//  edges     o_valid, o_result                    o_valid high (one cycle)
//  config    i_cfg_valid, o_cfg_ready, index/data i_cfg_valid and o_cfg_ready
//
// The front end handles a frame with two 20-step CORDIC runs plus a queue push
// and can take the next frame while the back end works. For each vertex
// the back end runs its two 30-step dividers side by side; once all eight
// vertices are done, it emits the frame's edges in order. Reset
// is synchronous and restores the register defaults. The receiver cannot
// stall, so every edge is shown for exactly one cycle; a two-entry queue
// lets the front end run ahead.
module wireframe_cube_edge_projector import wcep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    output logic                  o_valid,
    output t_out                  o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_trig q_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x        <= 10'd120;
            r_cfg.center_y        <= 10'd120;
            r_cfg.pixel_scale     <= 8'd88;
            r_cfg.camera_distance <= 16'd12288;
            r_cfg.depth_threshold <= 14'd2458;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:     r_cfg.center_x        <= i_cfg_data[9:0];
                CFG_CENTER_Y:     r_cfg.center_y        <= i_cfg_data[9:0];
                CFG_PIXEL_SCALE:  r_cfg.pixel_scale     <= i_cfg_data[7:0];
                CFG_CAMERA_DIST:  r_cfg.camera_distance <= i_cfg_data;
                CFG_DEPTH_THRESH: r_cfg.depth_threshold <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    wcep_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_trig  (q_trig),
        .i_q_pop   (q_pop)
    );

    wcep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_trig  (q_trig),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );
endmodule
